// ===== rtl/tro_pkg.sv =====
package tro_pkg;

  localparam int TRO_DEPTH = 16;
  localparam int REC_W     = 64;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ1  = 2'd1,
    FUNC_READ2  = 2'd2,
    FUNC_NOP    = 2'd3
  } tro_func_t;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_FULL      = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_PENDING   = 3'd3,
    STS_DELIVERED = 3'd4,
    STS_ALREADY   = 3'd5
  } tro_status_t;

  typedef enum logic {
    S_IDLE,
    S_POST
  } tro_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic post;
  } tro_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic out_free;
  } tro_sts_t;

endpackage

// ===== rtl/tro_stream_if.sv =====
interface tro_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic        [15:0] sensor_id;
  logic        [31:0] timestamp;
  logic signed [15:0] temperature;

  modport source (output valid, output func, output sensor_id, output timestamp,
                  output temperature, input ready);
  modport sink (input valid, input func, input sensor_id, input timestamp,
                input temperature, output ready);
endinterface

interface tro_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic        [15:0] out_sensor_id;
  logic        [31:0] out_timestamp;
  logic signed [15:0] out_temperature;
  logic               removed;

  modport source (output valid, output status, output out_sensor_id, output out_timestamp,
                  output out_temperature, output removed, input ready);
  modport sink (input valid, input status, input out_sensor_id, input out_timestamp,
                input out_temperature, input removed, output ready);
endinterface

// ===== rtl/tro_controller.sv =====
module tro_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tro_pkg::tro_sts_t sts,
  output tro_pkg::tro_cmd_t cmd
);
  import tro_pkg::*;

  tro_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        // The unused function code is consumed without a result.
        if (in_valid && !sts.skip) state_nxt = S_POST;
      end
      S_POST: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_POST: begin
        cmd.post = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/tro_datapath.sv =====
module tro_datapath #(
  parameter int DEPTH = tro_pkg::TRO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tro_pkg::tro_cmd_t  cmd,
  output tro_pkg::tro_sts_t  sts,
  input  logic        [1:0]  in_func,
  input  logic        [15:0] in_sensor_id,
  input  logic        [31:0] in_timestamp,
  input  logic signed [15:0] in_temperature,
  input  logic               out_ready,
  output logic               out_valid,
  output logic        [2:0]  out_status,
  output logic        [15:0] out_sensor_id,
  output logic        [31:0] out_timestamp,
  output logic signed [15:0] out_temperature,
  output logic               out_removed
);
  import tro_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [REC_W-1:0] mem [DEPTH];
  logic [REC_W-1:0] rd_data_r;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             head_read_r, head_read_nxt;

  tro_func_t   func;
  tro_status_t res_status;
  logic        res_has_rec;
  logic        res_removed;
  logic        wr_en;
  logic        rd_en;
  logic        empty;
  logic        full;

  tro_status_t res_status_r;
  logic        res_has_rec_r;
  logic        res_removed_r;
  logic        out_valid_r;

  assign func  = tro_func_t'(in_func);
  assign empty = (fill_r == '0);
  assign full  = (fill_r == FULL_CNT);

  assign sts.skip     = (func == FUNC_NOP);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    res_status    = STS_INSERTED;
    res_has_rec   = 1'b0;
    res_removed   = 1'b0;
    wr_en         = 1'b0;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    fill_nxt      = fill_r;
    head_read_nxt = head_read_r;
    case (func)
      FUNC_INSERT: begin
        if (full) begin
          res_status = STS_FULL;
        end else begin
          wr_en      = cmd.take;
          wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
          fill_nxt   = fill_r + 1'b1;
        end
      end
      FUNC_READ1: begin
        if (empty) begin
          res_status = STS_EMPTY;
        end else if (head_read_r) begin
          res_status = STS_ALREADY;
        end else begin
          res_status    = STS_DELIVERED;
          res_has_rec   = 1'b1;
          head_read_nxt = 1'b1;
        end
      end
      FUNC_READ2: begin
        if (empty) begin
          res_status = STS_EMPTY;
        end else if (!head_read_r) begin
          res_status = STS_PENDING;
        end else begin
          // The second reader's beat frees the head entry.
          res_status    = STS_DELIVERED;
          res_has_rec   = 1'b1;
          res_removed   = 1'b1;
          head_read_nxt = 1'b0;
          rd_ptr_nxt    = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
          fill_nxt      = fill_r - 1'b1;
        end
      end
      default: begin
        res_status = STS_INSERTED;
      end
    endcase
  end

  assign rd_en = cmd.take && res_has_rec;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= {in_sensor_id, in_timestamp, in_temperature};
    if (rd_en) rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      head_read_r <= 1'b0;
    end else if (cmd.take) begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      head_read_r <= head_read_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_status_r  <= res_status;
      res_has_rec_r <= res_has_rec;
      res_removed_r <= res_removed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.post) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_status      <= res_status_r;
      out_removed     <= res_removed_r;
      out_sensor_id   <= res_has_rec_r ? rd_data_r[63:48] : '0;
      out_timestamp   <= res_has_rec_r ? rd_data_r[47:16] : '0;
      out_temperature <= res_has_rec_r ? $signed(rd_data_r[15:0]) : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/two_reader_ordered_fifo_core.sv =====
// Ordered record FIFO shared by two readers.
// in_ch carries one request per beat: func selects an insert of the
// record (sensor_id, timestamp, temperature), a read by the first reader,
// or a read by the second reader. out_ch carries one result per request:
// a status, the head record when it was delivered, and a flag set when
// the second reader's read freed the head. The unused func code is taken
// and produces no result.
// The record store is a DEPTH-entry memory with a registered read port.
// A request is taken in S_IDLE and its result is registered; in S_POST
// the result is loaded into the output register once that register is
// free. in_ch.ready is low in S_POST, so a new request is taken only
// after the result of the last one has been loaded.
// The output register lets a new request be taken while a result waits.
// When out_ch stalls, at most one further request is held until the
// output register frees; in_ch.ready stays low meanwhile.
// After reset the store is empty, both pointers are zero and the head is
// unread; no clearing pass is needed.
module two_reader_ordered_fifo_core #(
  parameter int DEPTH = tro_pkg::TRO_DEPTH
) (
  input logic clk,
  input logic rst_n,
  tro_in_if.sink    in_ch,
  tro_out_if.source out_ch
);
  import tro_pkg::*;

  tro_cmd_t cmd;
  tro_sts_t sts;

  tro_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tro_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_ch.func),
    .in_sensor_id    (in_ch.sensor_id),
    .in_timestamp    (in_ch.timestamp),
    .in_temperature  (in_ch.temperature),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_sensor_id   (out_ch.out_sensor_id),
    .out_timestamp   (out_ch.out_timestamp),
    .out_temperature (out_ch.out_temperature),
    .out_removed     (out_ch.removed)
  );

endmodule
